// ----- design/ffca_pkg.sv -----
// Shared constants, codes and sequencer state type for the first-fit chunk allocator.
// No dependencies; the top level refers to it by scoped names.
`default_nettype none

package ffca_pkg;

  // Fixed field widths
  localparam int LEN_BITS  = 21;
  localparam int POOL_BITS = 21;

  // Defaults for top-level parameters
  localparam int DEF_MAX_CHUNKS  = 16;
  localparam int DEF_OFFSET_BITS = 20;

  localparam logic [POOL_BITS-1:0] POOL_RESET = 21'd65536;

  // Action codes
  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_FREE    = 2'd1;
  localparam logic [1:0] ACT_REALLOC = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NO_ROOM    = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND  = 2'd2;
  localparam logic [1:0] STAT_TABLE_FULL = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_ADV,
    S_LAST,
    S_GROW,
    S_RMV,
    S_RMV_END,
    S_INS,
    S_PUT,
    S_DONE
  } seq_state_t;

endpackage

`default_nettype wire

// ----- design/ffca_table.sv -----
// Chunk table memory: start and length per entry, one write port, one registered read.
// Uses no package items; widths come from the top level.
`default_nettype none

module ffca_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int OW    = 20,
  parameter int LW    = 21
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [OW-1:0] wr_start,
  input  wire logic [LW-1:0] wr_len,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [OW-1:0] rd_start,
  output logic      [LW-1:0] rd_len
);

  logic [OW-1:0] start_mem [DEPTH];
  logic [LW-1:0] len_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[wr_addr] <= wr_start;
      len_mem[wr_addr]   <= wr_len;
    end
  end

  always_ff @(posedge clk) begin
    rd_start <= start_mem[rd_addr];
    rd_len   <= len_mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- design/ffca_alu.sv -----
// Shared adder with two upper-bound compares, used for every end and fit computation.
// Uses no package items.
`default_nettype none

module ffca_alu #(
  parameter int SW = 23
) (
  input  wire logic [SW-1:0] a,
  input  wire logic [SW-1:0] b,
  input  wire logic [SW-1:0] lim_a,
  input  wire logic [SW-1:0] lim_b,
  output logic      [SW-1:0] sum,
  output logic               le_a,
  output logic               le_b
);

  assign sum  = a + b;
  assign le_a = (sum <= lim_a);
  assign le_b = (sum <= lim_b);

endmodule

`default_nettype wire

// ----- design/first_fit_chunk_allocator.sv -----
// Top level of the first-fit chunk allocator: request sequencer, counters, result register.
// Depends on ffca_pkg, ffca_table and ffca_alu.
//
//   channel  direction  handshake           payload
//   in_      to block   in_valid/in_stall   in_action, in_chunk_offset, in_request_size
//   out_     from block out_valid/out_stall status, offset, moved, copy, count, bytes
//   cfg_     to block   cfg_valid/cfg_ready cfg_pool_size
//
// One request at a time. When matching an offset the scan tests each entry in S_CHK; when
// searching for a gap each entry is tested in S_CHK and then passed in S_ADV (shared adder:
// gap end, then chunk end), and entries shifted on insert or remove pass through S_INS or S_RMV.
// A reallocate that moves its chunk is the longest case. After its result is taken the
// sequencer returns to S_IDLE before it accepts the next request.
// Synchronous active-low reset clears the count, bytes in use and sequencer and loads the
// default pool size; table contents are not cleared. A stalled result holds in the output register.
`default_nettype none

module first_fit_chunk_allocator #(
  parameter int MAX_CHUNKS  = ffca_pkg::DEF_MAX_CHUNKS,
  parameter int OFFSET_BITS = ffca_pkg::DEF_OFFSET_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // request channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_action,
  input  wire logic [OFFSET_BITS-1:0]             in_chunk_offset,
  input  wire logic [ffca_pkg::LEN_BITS-1:0]      in_request_size,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              out_status,
  output logic [OFFSET_BITS-1:0]                  out_result_offset,
  output logic                                    out_moved,
  output logic [ffca_pkg::LEN_BITS-1:0]           out_copy_bytes,
  output logic [$clog2(MAX_CHUNKS+1)-1:0]         out_chunk_count,
  output logic [ffca_pkg::LEN_BITS-1:0]           out_bytes_in_use,
  // configuration
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ffca_pkg::POOL_BITS-1:0]     cfg_pool_size
);

  localparam int OW = OFFSET_BITS;
  localparam int LW = ffca_pkg::LEN_BITS;
  localparam int IW = $clog2(MAX_CHUNKS);
  localparam int CW = $clog2(MAX_CHUNKS + 1);
  localparam int SW = ((OW > LW) ? OW : LW) + 2;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CHUNKS);
  localparam logic [SW-1:0] SPAN    = SW'(64'd1 << OFFSET_BITS);

  ffca_pkg::seq_state_t st_r, st_nxt;

  logic [1:0]                      act_r, act_nxt;
  logic [OW-1:0]                   off_r, off_nxt;
  logic [LW-1:0]                   size_r, size_nxt;
  logic                            gap_r, gap_nxt;      // scanning for a gap, not a match
  logic [CW-1:0]                   k_r, k_nxt;          // scan index
  logic [CW-1:0]                   j_r, j_nxt;          // shift index
  logic [CW-1:0]                   fk_r, fk_nxt;        // index of matched chunk
  logic [CW-1:0]                   ip_r, ip_nxt;        // insert position
  logic [SW-1:0]                   prev_end_r, prev_end_nxt;
  logic [LW-1:0]                   old_len_r, old_len_nxt;
  logic [OW-1:0]                   where_r, where_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [LW-1:0]                   held_r, held_nxt;
  logic [ffca_pkg::POOL_BITS-1:0]  pool_r;

  logic [1:0]                      status_r, status_nxt;
  logic [OW-1:0]                   roff_r, roff_nxt;
  logic                            moved_r, moved_nxt;
  logic [LW-1:0]                   copy_r, copy_nxt;

  // table port
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic [OW-1:0]   wr_start;
  logic [LW-1:0]   wr_len;
  logic [IW-1:0]   rd_addr;
  logic [OW-1:0]   rd_start;
  logic [LW-1:0]   rd_len;

  // shared adder
  logic [SW-1:0]   alu_a, alu_b, alu_lim_a, alu_lim_b, alu_sum;
  logic            alu_le_a, alu_le_b;

  logic [SW-1:0]   pool_use;
  logic [CW-1:0]   k_inc, j_inc, j_inc2, j_dec, cnt_dec, cnt_dec2, ip_adj;

  assign pool_use = (SW'(pool_r) < SPAN) ? SW'(pool_r) : SPAN;
  assign k_inc    = k_r + CW'(1);
  assign j_inc    = j_r + CW'(1);
  assign j_inc2   = j_r + CW'(2);
  assign j_dec    = j_r - CW'(1);
  assign cnt_dec  = cnt_r - CW'(1);
  assign cnt_dec2 = cnt_r - CW'(2);
  // after removing the old chunk, a higher insert slot moves down by one
  assign ip_adj   = (ip_r > fk_r) ? (ip_r - CW'(1)) : ip_r;

  ffca_table #(
    .DEPTH (MAX_CHUNKS),
    .AW    (IW),
    .OW    (OW),
    .LW    (LW)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_start (wr_start),
    .wr_len   (wr_len),
    .rd_addr  (rd_addr),
    .rd_start (rd_start),
    .rd_len   (rd_len)
  );

  ffca_alu #(
    .SW (SW)
  ) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .lim_a (alu_lim_a),
    .lim_b (alu_lim_b),
    .sum   (alu_sum),
    .le_a  (alu_le_a),
    .le_b  (alu_le_b)
  );

  assign in_stall          = (st_r != ffca_pkg::S_IDLE);
  assign out_valid         = (st_r == ffca_pkg::S_DONE);
  assign out_status        = status_r;
  assign out_result_offset = roff_r;
  assign out_moved         = moved_r;
  assign out_copy_bytes    = copy_r;
  assign out_chunk_count   = cnt_r;
  assign out_bytes_in_use  = held_r;
  assign cfg_ready         = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ffca_pkg::S_IDLE;
      cnt_r  <= '0;
      held_r <= '0;
      pool_r <= ffca_pkg::POOL_RESET;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      held_r <= held_nxt;
      if (cfg_valid && cfg_ready) begin
        pool_r <= cfg_pool_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    off_r      <= off_nxt;
    size_r     <= size_nxt;
    gap_r      <= gap_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    fk_r       <= fk_nxt;
    ip_r       <= ip_nxt;
    prev_end_r <= prev_end_nxt;
    old_len_r  <= old_len_nxt;
    where_r    <= where_nxt;
    status_r   <= status_nxt;
    roff_r     <= roff_nxt;
    moved_r    <= moved_nxt;
    copy_r     <= copy_nxt;
  end

  always_comb begin
    st_nxt       = st_r;
    act_nxt      = act_r;
    off_nxt      = off_r;
    size_nxt     = size_r;
    gap_nxt      = gap_r;
    k_nxt        = k_r;
    j_nxt        = j_r;
    fk_nxt       = fk_r;
    ip_nxt       = ip_r;
    prev_end_nxt = prev_end_r;
    old_len_nxt  = old_len_r;
    where_nxt    = where_r;
    cnt_nxt      = cnt_r;
    held_nxt     = held_r;
    status_nxt   = status_r;
    roff_nxt     = roff_r;
    moved_nxt    = moved_r;
    copy_nxt     = copy_r;

    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = j_r[IW-1:0];
    wr_start  = rd_start;
    wr_len    = rd_len;

    // default adder use: candidate gap start plus requested size
    alu_a     = prev_end_r;
    alu_b     = SW'(size_r);
    alu_lim_a = SW'(rd_start);
    alu_lim_b = pool_use;

    unique case (st_r)
      ffca_pkg::S_IDLE: begin
        if (in_valid) begin
          act_nxt      = in_action;
          off_nxt      = in_chunk_offset;
          size_nxt     = in_request_size;
          k_nxt        = '0;
          prev_end_nxt = '0;
          gap_nxt      = (in_action == ffca_pkg::ACT_ALLOC);
          status_nxt   = ffca_pkg::STAT_OK;
          roff_nxt     = '0;
          moved_nxt    = 1'b0;
          copy_nxt     = '0;
          if (in_action == ffca_pkg::ACT_ALLOC) begin
            if (in_request_size == '0) begin
              status_nxt = ffca_pkg::STAT_NO_ROOM;
              st_nxt     = ffca_pkg::S_DONE;
            end else if (cnt_r >= MAX_CNT) begin
              status_nxt = ffca_pkg::STAT_TABLE_FULL;
              st_nxt     = ffca_pkg::S_DONE;
            end else if (cnt_r == '0) begin
              st_nxt = ffca_pkg::S_LAST;
            end else begin
              st_nxt = ffca_pkg::S_CHK;
            end
          end else if (in_action == ffca_pkg::ACT_FREE ||
                       in_action == ffca_pkg::ACT_REALLOC) begin
            if (cnt_r == '0) begin
              status_nxt = ffca_pkg::STAT_NOT_FOUND;
              st_nxt     = ffca_pkg::S_DONE;
            end else begin
              st_nxt = ffca_pkg::S_CHK;
            end
          end else begin
            status_nxt = ffca_pkg::STAT_NOT_FOUND;
            st_nxt     = ffca_pkg::S_DONE;
          end
        end
      end

      // Entry k is on the read port. Either match the request offset or test the
      // gap that ends at this entry's start.
      ffca_pkg::S_CHK: begin
        rd_addr = k_r[IW-1:0];
        if (!gap_r) begin
          if (rd_start == off_r) begin
            fk_nxt      = k_r;
            old_len_nxt = rd_len;
            if (act_r == ffca_pkg::ACT_FREE) begin
              if (k_inc < cnt_r) begin
                j_nxt   = k_r;
                rd_addr = k_inc[IW-1:0];
                st_nxt  = ffca_pkg::S_RMV;
              end else begin
                st_nxt = ffca_pkg::S_RMV_END;
              end
            end else if (size_r == '0) begin
              status_nxt = ffca_pkg::STAT_NO_ROOM;
              st_nxt     = ffca_pkg::S_DONE;
            end else if (size_r <= rd_len) begin
              // shrink in place
              wr_en      = 1'b1;
              wr_addr    = k_r[IW-1:0];
              wr_start   = off_r;
              wr_len     = size_r;
              held_nxt   = held_r - rd_len + size_r;
              roff_nxt   = off_r;
              st_nxt     = ffca_pkg::S_DONE;
            end else begin
              alu_a = SW'(off_r);
              if (k_inc < cnt_r) begin
                // fetch the next higher chunk for the grow check
                rd_addr = k_inc[IW-1:0];
                st_nxt  = ffca_pkg::S_GROW;
              end else if (alu_le_b) begin
                wr_en    = 1'b1;
                wr_addr  = k_r[IW-1:0];
                wr_start = off_r;
                wr_len   = size_r;
                held_nxt = held_r - rd_len + size_r;
                roff_nxt = off_r;
                st_nxt   = ffca_pkg::S_DONE;
              end else begin
                gap_nxt      = 1'b1;
                k_nxt        = '0;
                prev_end_nxt = '0;
                rd_addr      = '0;
                st_nxt       = ffca_pkg::S_CHK;
              end
            end
          end else if (k_inc == cnt_r) begin
            status_nxt = ffca_pkg::STAT_NOT_FOUND;
            st_nxt     = ffca_pkg::S_DONE;
          end else begin
            k_nxt   = k_inc;
            rd_addr = k_inc[IW-1:0];
          end
        end else begin
          if (alu_le_a && alu_le_b) begin
            where_nxt = prev_end_r[OW-1:0];
            roff_nxt  = prev_end_r[OW-1:0];
            ip_nxt    = k_r;
            if (act_r == ffca_pkg::ACT_ALLOC) begin
              if (cnt_r > k_r) begin
                j_nxt   = cnt_dec;
                rd_addr = cnt_dec[IW-1:0];
                st_nxt  = ffca_pkg::S_INS;
              end else begin
                st_nxt = ffca_pkg::S_PUT;
              end
            end else begin
              moved_nxt = 1'b1;
              copy_nxt  = old_len_r;
              if (fk_r + CW'(1) < cnt_r) begin
                j_nxt   = fk_r;
                rd_addr = IW'(fk_r + CW'(1));
                st_nxt  = ffca_pkg::S_RMV;
              end else begin
                st_nxt = ffca_pkg::S_RMV_END;
              end
            end
          end else begin
            st_nxt = ffca_pkg::S_ADV;
          end
        end
      end

      // Advance the candidate to the end of entry k and fetch the next entry, or go to S_LAST after the highest one.
      ffca_pkg::S_ADV: begin
        alu_a        = SW'(rd_start);
        alu_b        = SW'(rd_len);
        prev_end_nxt = alu_sum;
        k_nxt        = k_inc;
        if (k_inc == cnt_r) begin
          st_nxt = ffca_pkg::S_LAST;
        end else begin
          rd_addr = k_inc[IW-1:0];
          st_nxt  = ffca_pkg::S_CHK;
        end
      end

      // Gap after the highest chunk: only the pool bound applies.
      ffca_pkg::S_LAST: begin
        if (alu_le_b) begin
          where_nxt = prev_end_r[OW-1:0];
          roff_nxt  = prev_end_r[OW-1:0];
          ip_nxt    = cnt_r;
          if (act_r == ffca_pkg::ACT_ALLOC) begin
            st_nxt = ffca_pkg::S_PUT;
          end else begin
            moved_nxt = 1'b1;
            copy_nxt  = old_len_r;
            if (fk_r + CW'(1) < cnt_r) begin
              j_nxt   = fk_r;
              rd_addr = IW'(fk_r + CW'(1));
              st_nxt  = ffca_pkg::S_RMV;
            end else begin
              st_nxt = ffca_pkg::S_RMV_END;
            end
          end
        end else begin
          status_nxt = ffca_pkg::STAT_NO_ROOM;
          roff_nxt   = '0;
          st_nxt     = ffca_pkg::S_DONE;
        end
      end

      // Next higher chunk is on the read port: grow in place or search elsewhere.
      ffca_pkg::S_GROW: begin
        alu_a = SW'(off_r);
        if (alu_le_a && alu_le_b) begin
          wr_en    = 1'b1;
          wr_addr  = fk_r[IW-1:0];
          wr_start = off_r;
          wr_len   = size_r;
          held_nxt = held_r - old_len_r + size_r;
          roff_nxt = off_r;
          st_nxt   = ffca_pkg::S_DONE;
        end else begin
          gap_nxt      = 1'b1;
          k_nxt        = '0;
          prev_end_nxt = '0;
          rd_addr      = '0;
          st_nxt       = ffca_pkg::S_CHK;
        end
      end

      // Shift entry j+1 down into slot j.
      ffca_pkg::S_RMV: begin
        wr_en   = 1'b1;
        wr_addr = j_r[IW-1:0];
        if (j_inc2 < cnt_r) begin
          j_nxt   = j_inc;
          rd_addr = j_inc2[IW-1:0];
        end else begin
          st_nxt = ffca_pkg::S_RMV_END;
        end
      end

      ffca_pkg::S_RMV_END: begin
        cnt_nxt  = cnt_dec;
        held_nxt = held_r - old_len_r;
        if (act_r == ffca_pkg::ACT_FREE) begin
          roff_nxt = off_r;
          st_nxt   = ffca_pkg::S_DONE;
        end else begin
          ip_nxt = ip_adj;
          if (cnt_dec > ip_adj) begin
            j_nxt   = cnt_dec2;
            rd_addr = cnt_dec2[IW-1:0];
            st_nxt  = ffca_pkg::S_INS;
          end else begin
            st_nxt = ffca_pkg::S_PUT;
          end
        end
      end

      // Shift entry j up into slot j+1, walking down to the insert slot.
      ffca_pkg::S_INS: begin
        wr_en   = 1'b1;
        wr_addr = j_inc[IW-1:0];
        if (j_r > ip_r) begin
          j_nxt   = j_dec;
          rd_addr = j_dec[IW-1:0];
        end else begin
          st_nxt = ffca_pkg::S_PUT;
        end
      end

      ffca_pkg::S_PUT: begin
        wr_en    = 1'b1;
        wr_addr  = ip_r[IW-1:0];
        wr_start = where_r;
        wr_len   = size_r;
        cnt_nxt  = cnt_r + CW'(1);
        held_nxt = held_r + size_r;
        st_nxt   = ffca_pkg::S_DONE;
      end

      ffca_pkg::S_DONE: begin
        if (!out_stall) begin
          st_nxt = ffca_pkg::S_IDLE;
        end
      end

      default: begin
        st_nxt = ffca_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for first_fit_chunk_allocator: directed request table, then random
// request streams over several pool sizes, checked against typed rows or a table model.
// Depends on ffca_pkg and the allocator RTL only.

module tb_top;

  localparam int MAX_CHUNKS  = 16;
  localparam int OFFSET_BITS = 20;
  localparam int LEN_BITS    = ffca_pkg::LEN_BITS;
  localparam int POOL_BITS   = ffca_pkg::POOL_BITS;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam longint OFFSET_SPAN = 64'd1 << OFFSET_BITS;
  localparam int DRAIN_CYCLES = 2 * MAX_CHUNKS + 30;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]             status;
    logic [OFFSET_BITS-1:0] offset;
    logic                   moved;
    logic [LEN_BITS-1:0]    copy_bytes;
    logic [4:0]             count;
    logic [LEN_BITS-1:0]    bytes;
  } alloc_result_t;

  typedef struct {
    logic [1:0]             action;
    logic [OFFSET_BITS-1:0] offset;
    logic [LEN_BITS-1:0]    size;
    bit                     typed;
    alloc_result_t          result;
  } request_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             in_action = '0;
  logic [OFFSET_BITS-1:0] in_chunk_offset = '0;
  logic [LEN_BITS-1:0]    in_request_size = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             out_status;
  logic [OFFSET_BITS-1:0] out_result_offset;
  logic                   out_moved;
  logic [LEN_BITS-1:0]    out_copy_bytes;
  logic [4:0]             out_chunk_count;
  logic [LEN_BITS-1:0]    out_bytes_in_use;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [POOL_BITS-1:0]   cfg_pool_size = '0;

  first_fit_chunk_allocator #(
    .MAX_CHUNKS(MAX_CHUNKS),
    .OFFSET_BITS(OFFSET_BITS)
  ) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_chunk_offset(in_chunk_offset), .in_request_size(in_request_size),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_result_offset(out_result_offset), .out_moved(out_moved),
    .out_copy_bytes(out_copy_bytes), .out_chunk_count(out_chunk_count),
    .out_bytes_in_use(out_bytes_in_use),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_pool_size(cfg_pool_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the chunk table, kept sorted by start offset.
  longint chunk_start [MAX_CHUNKS];
  longint chunk_len   [MAX_CHUNKS];
  int     chunk_count;
  longint bytes_held;
  longint pool_bytes;

  alloc_result_t pending_results[$];
  request_row_t  request_rows[$];
  int  error_count = 0;
  bit  quiet = 1'b0;      // no idling on either side while set
  longint cycle_count = 0;

  function automatic longint usable_pool();
    return (pool_bytes < OFFSET_SPAN) ? pool_bytes : OFFSET_SPAN;
  endfunction

  function automatic bit gap_fits(longint p, longint s);
    for (int i = 0; i < chunk_count; i++) begin
      if (chunk_start[i] == p) return 1'b0;
      if (chunk_start[i] > p && chunk_start[i] - p < s) return 1'b0;
      if (chunk_start[i] < p && chunk_start[i] + chunk_len[i] > p) return 1'b0;
    end
    return (p + s <= usable_pool());
  endfunction

  // First fit: offset 0, then the end of each chunk in address order.
  function automatic bit first_fit(longint s, output longint where);
    where = 0;
    if (gap_fits(0, s)) return 1'b1;
    for (int i = 0; i < chunk_count; i++) begin
      where = chunk_start[i] + chunk_len[i];
      if (gap_fits(where, s)) return 1'b1;
    end
    where = 0;
    return 1'b0;
  endfunction

  function automatic int chunk_index(longint off);
    for (int i = 0; i < chunk_count; i++)
      if (chunk_start[i] == off) return i;
    return -1;
  endfunction

  function automatic void drop_chunk(int k);
    bytes_held -= chunk_len[k];
    for (int i = k; i + 1 < chunk_count; i++) begin
      chunk_start[i] = chunk_start[i+1];
      chunk_len[i] = chunk_len[i+1];
    end
    chunk_count--;
  endfunction

  function automatic void place_chunk(longint st, longint len);
    int i;
    i = chunk_count;
    if (chunk_count >= MAX_CHUNKS) return;
    while (i > 0 && chunk_start[i-1] > st) begin
      chunk_start[i] = chunk_start[i-1];
      chunk_len[i] = chunk_len[i-1];
      i--;
    end
    chunk_start[i] = st;
    chunk_len[i] = len;
    chunk_count++;
    bytes_held += len;
  endfunction

  // Apply one request to the shadow table and return the result it must produce.
  function automatic alloc_result_t apply_request(logic [1:0] act, longint off, longint size);
    alloc_result_t r;
    longint where, old;
    int k;
    r = '0;
    where = 0;
    case (act)
      ffca_pkg::ACT_ALLOC: begin
        if (size == 0) r.status = ffca_pkg::STAT_NO_ROOM;
        else if (chunk_count >= MAX_CHUNKS) r.status = ffca_pkg::STAT_TABLE_FULL;
        else if (!first_fit(size, where)) r.status = ffca_pkg::STAT_NO_ROOM;
        else begin
          place_chunk(where, size);
          r.offset = OFFSET_BITS'(where);
        end
      end
      ffca_pkg::ACT_FREE: begin
        k = chunk_index(off);
        if (k < 0) r.status = ffca_pkg::STAT_NOT_FOUND;
        else begin
          drop_chunk(k);
          r.offset = OFFSET_BITS'(off);
        end
      end
      ffca_pkg::ACT_REALLOC: begin
        k = chunk_index(off);
        if (k < 0) r.status = ffca_pkg::STAT_NOT_FOUND;
        else if (size == 0) r.status = ffca_pkg::STAT_NO_ROOM;
        else begin
          old = chunk_len[k];
          // Shrink, or grow when neither the next chunk nor the pool end is in the way.
          if (size <= old || (off + size <= usable_pool() &&
              !(k + 1 < chunk_count && off + size > chunk_start[k+1]))) begin
            bytes_held = bytes_held - old + size;
            chunk_len[k] = size;
            r.offset = OFFSET_BITS'(off);
          end else if (first_fit(size, where)) begin
            drop_chunk(k);
            place_chunk(where, size);
            r.offset = OFFSET_BITS'(where);
            r.moved = 1'b1;
            r.copy_bytes = LEN_BITS'(old);
          end else r.status = ffca_pkg::STAT_NO_ROOM;
        end
      end
      default: r.status = ffca_pkg::STAT_NOT_FOUND;
    endcase
    r.count = 5'(chunk_count);
    r.bytes = LEN_BITS'(bytes_held);
    return r;
  endfunction

  function automatic void add_row(logic [1:0] act, longint off, longint size, bit typed,
                                  logic [1:0] st, longint roff, int cnt, longint bytes);
    request_row_t row;
    row.action = act;
    row.offset = OFFSET_BITS'(off);
    row.size = LEN_BITS'(size);
    row.typed = typed;
    row.result = '0;
    row.result.status = st;
    row.result.offset = OFFSET_BITS'(roff);
    row.result.count = 5'(cnt);
    row.result.bytes = LEN_BITS'(bytes);
    request_rows.push_back(row);
  endfunction

  // Drive one request, hold it until accepted, then log its expected result.
  task automatic send_request(logic [1:0] act, longint off, longint size, bit typed,
                              alloc_result_t typed_result);
    alloc_result_t r;
    while (!quiet && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_chunk_offset <= OFFSET_BITS'(off);
    in_request_size <= LEN_BITS'(size);
    do @(posedge clk); while (in_stall);
    r = apply_request(act, off, size);
    pending_results.push_back(typed ? typed_result : r);
  endtask

  // Wait for every result, let the block settle, then load a new pool size.
  task automatic set_pool(longint bytes);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_pool_size <= POOL_BITS'(bytes);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pool_bytes = bytes;
  endtask

  // Mostly well-formed traffic: free and resize name held chunks, sizes suit the pool.
  task automatic random_requests(int n);
    logic [1:0] act;
    longint off, size, top;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      act = (pick < 45) ? ffca_pkg::ACT_ALLOC : (pick < 70) ? ffca_pkg::ACT_FREE :
            (pick < 98) ? ffca_pkg::ACT_REALLOC : ACT_UNUSED;
      if (chunk_count > 0 && $urandom_range(0, 99) < 85)
        off = chunk_start[$urandom_range(0, chunk_count - 1)];
      else off = $urandom_range(0, OFFSET_SPAN - 1);
      top = usable_pool() / 5;
      if (top < 1) top = 1;
      pick = $urandom_range(0, 99);
      if (pick < 3) size = 0;
      else if (pick < 8) size = $urandom_range(1, 1048576);
      else size = $urandom_range(1, top);
      send_request(act, off, size, 1'b0, '0);
    end
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Result side: random stall, compare each accepted result with the oldest one logged.
  always @(posedge clk) begin
    alloc_result_t want;
    out_stall <= !quiet && ($urandom_range(0, 99) < 18);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d offset %0d", $time, out_status,
                 out_result_offset);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("result_offset", want.offset, out_result_offset);
        check_field("moved", want.moved, out_moved);
        check_field("copy_bytes", want.copy_bytes, out_copy_bytes);
        check_field("chunk_count", want.count, out_chunk_count);
        check_field("bytes_in_use", want.bytes, out_bytes_in_use);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    chunk_count = 0;
    bytes_held = 0;
    pool_bytes = ffca_pkg::POOL_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table errors, size extremes, shrink, grow, unused action,
    // then fill the table to full and force a move while full.
    add_row(ffca_pkg::ACT_FREE, 0, 1, 1, ffca_pkg::STAT_NOT_FOUND, 0, 0, 0);
    add_row(ffca_pkg::ACT_ALLOC, 0, 0, 1, ffca_pkg::STAT_NO_ROOM, 0, 0, 0);
    add_row(ffca_pkg::ACT_ALLOC, 0, 1048576, 1, ffca_pkg::STAT_NO_ROOM, 0, 0, 0);
    add_row(ffca_pkg::ACT_ALLOC, 0, 65536, 1, ffca_pkg::STAT_OK, 0, 1, 65536);
    add_row(ffca_pkg::ACT_ALLOC, 0, 1, 1, ffca_pkg::STAT_NO_ROOM, 0, 1, 65536);
    add_row(ffca_pkg::ACT_REALLOC, 0, 4096, 1, ffca_pkg::STAT_OK, 0, 1, 4096);
    add_row(ffca_pkg::ACT_REALLOC, 0, 8192, 1, ffca_pkg::STAT_OK, 0, 1, 8192);
    add_row(ACT_UNUSED, 20'hFFFFF, 21'h1FFFFF, 1, ffca_pkg::STAT_NOT_FOUND, 0, 1, 8192);
    add_row(ffca_pkg::ACT_REALLOC, 20'hFFFFF, 1, 1, ffca_pkg::STAT_NOT_FOUND, 0, 1, 8192);
    add_row(ffca_pkg::ACT_REALLOC, 0, 0, 1, ffca_pkg::STAT_NO_ROOM, 0, 1, 8192);
    for (int i = 0; i < MAX_CHUNKS - 1; i++)
      add_row(ffca_pkg::ACT_ALLOC, 0, 1000 + i, 0, ffca_pkg::STAT_OK, 0, 0, 0);
    add_row(ffca_pkg::ACT_ALLOC, 0, 1, 1, ffca_pkg::STAT_TABLE_FULL, 0, 0, 0);
    add_row(ffca_pkg::ACT_REALLOC, 0, 9000, 0, ffca_pkg::STAT_OK, 0, 0, 0);
    add_row(ffca_pkg::ACT_FREE, 8192, 1, 0, ffca_pkg::STAT_OK, 0, 0, 0);
    foreach (request_rows[i]) begin
      if (request_rows[i].typed &&
          request_rows[i].result.status == ffca_pkg::STAT_TABLE_FULL) begin
        request_rows[i].result.count = 5'(MAX_CHUNKS);
        request_rows[i].result.bytes = LEN_BITS'(bytes_held);
      end
      send_request(request_rows[i].action, request_rows[i].offset, request_rows[i].size,
                   request_rows[i].typed, request_rows[i].result);
    end

    random_requests(170);
    set_pool(1);
    random_requests(40);
    set_pool(1048576);
    quiet = 1'b1;
    random_requests(150);
    quiet = 1'b0;
    random_requests(50);
    set_pool($urandom_range(64, 4096));
    random_requests(250);
    set_pool($urandom_range(4096, 65536));
    random_requests(260);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
